// File: sv/imu_sample_conditioner_macros.svh
// Assertion macros shared by the conditioner RTL
`ifndef IMU_SAMPLE_CONDITIONER_MACROS_SVH
`define IMU_SAMPLE_CONDITIONER_MACROS_SVH

// condition checked at every rising clock edge outside reset
`define ISC_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent implies consequent in the following cycle
`define ISC_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/isc_pkg.sv
// Shared constants for the IMU sample conditioner
package isc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 63;
	localparam int PACK_W = 21;
	localparam int WEIGHT_W = 17;
	localparam int DT_W = 17;
	localparam int MUL_BW = 30;
	localparam int REM_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd5;

	localparam logic [CFG_DATA_W-1:0] ROW_X_RST = 63'd262144;
	localparam logic [CFG_DATA_W-1:0] ROW_Y_RST = 63'd549755813888;
	localparam logic [CFG_DATA_W-1:0] ROW_Z_RST = 63'd1152921504606846976;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd62259;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

	localparam logic [DT_W-1:0] DT_MAX = 17'd100000;
	localparam logic [DT_W-1:0] DT_DEFAULT = 17'd10000;
	localparam logic [REM_W-1:0] US_PER_S = 20'd1000000;

	localparam longint FILT_RND = 32768;
	localparam longint MAT_RND = 131072;
	localparam longint INT_RND = 500000;
	localparam longint PI_Q = 843314857;
	localparam longint TWO_PI_Q = 1686629713;

endpackage

// File: sv/isc_mul.sv
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle
module isc_mul import isc_pkg::*; #(
	parameter int AW = 34,
	parameter int BW = 30
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	input  logic signed [AW+BW-1:0]  init,
	output logic                     busy,
	output logic                     done,
	output logic signed [AW+BW-1:0]  prod
);
	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW);

	logic signed [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic signed [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic last;
	logic signed [PW-1:0] addend;

	assign last = (cnt_q == CW'(BW - 1));

	always_comb begin
		addend = '0;
		if (b_q[0]) begin
			// top bit of b carries negative weight
			addend = last ? -a_q : a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= PW'(a);
			b_q <= b;
			acc_q <= init;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: sv/isc_div.sv
// Bit-serial restoring divide by one million, one quotient bit per cycle
module isc_div import isc_pkg::*; #(
	parameter int NW = 61
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW);

	logic [NW-1:0] n_q, q_q;
	logic [REM_W-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [REM_W:0] r2;
	logic ge;

	assign r2 = {rem_q, n_q[NW-1]};
	assign ge = (r2 >= {1'b0, US_PER_S});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			q_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			q_q <= {q_q[NW-2:0], ge};
			rem_q <= ge ? REM_W'(r2 - {1'b0, US_PER_S}) : r2[REM_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = q_q;

endmodule

// File: sv/imu_sample_conditioner.sv
// Top level: config registers, sequencer, filter, matrix and angle integration
//
// channel  | direction | handshake                   | payload
// sample   | in        | sample_valid / sample_ready | operation, sample_x/y/z, time_us
// result   | out       | result_valid / result_ready | source, rate_*, accel_*, roll/pitch/yaw
// cfg      | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// All products go through one bit-serial multiplier of 30 bit steps. The angle step uses
// a serial divider of SAMPLE_WIDTH+29 bit steps. A gyro word runs six products and three
// divides before its result is loaded, an accel word twelve products. The first gyro
// word only seeds the timestamp and gives no result. The next word can be taken in the
// cycle after the result is loaded; a finished result waits in the output register while
// the next word runs. cfg_ready is always high.
module imu_sample_conditioner import isc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int TIME_WIDTH = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic                           operation,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_x,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_y,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_z,
	input  logic [TIME_WIDTH-1:0]          time_us,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           source,
	output logic signed [31:0]             rate_x,
	output logic signed [31:0]             rate_y,
	output logic signed [31:0]             rate_z,
	output logic signed [31:0]             accel_x,
	output logic signed [31:0]             accel_y,
	output logic signed [31:0]             accel_z,
	output logic signed [31:0]             roll,
	output logic signed [31:0]             pitch,
	output logic signed [31:0]             yaw,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);
`include "imu_sample_conditioner_macros.svh"

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = SW + 2;
	localparam int BW = MUL_BW;
	localparam int PW = AW + BW;
	localparam int NW = SW + 29;
	localparam int AGW = SW + 34;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GFILT = 3'd1;
	localparam logic [2:0] ST_INTMUL = 3'd2;
	localparam logic [2:0] ST_INTDIV = 3'd3;
	localparam logic [2:0] ST_AMAT = 3'd4;
	localparam logic [2:0] ST_AFILT = 3'd5;
	localparam logic [2:0] ST_FIN = 3'd6;

	localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(64'sd1);
	localparam logic signed [AGW-1:0] A_PI = AGW'(PI_Q);
	localparam logic signed [AGW-1:0] A_2PI = AGW'(TWO_PI_Q);
	localparam logic signed [AGW-1:0] A_HI = AGW'(64'sd2147483647);
	localparam logic signed [AGW-1:0] A_LO = AGW'(-64'sd2147483648);

	function automatic logic signed [SW-1:0] sat_sw(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] r;
		r = v;
		if (v > SAT_HI) r = SAT_HI;
		else if (v < SAT_LO) r = SAT_LO;
		return r[SW-1:0];
	endfunction

	function automatic logic [31:0] to32(input logic signed [SW-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[31:0];
	endfunction

	// config registers
	logic [CFG_DATA_W-1:0] gbias_q, abias_q, row_x_q, row_y_q, row_z_q;
	logic [WEIGHT_W-1:0] weight_q;

	// sequencer and state
	logic [2:0] state_q;
	logic [1:0] axis_q, term_q;
	logic op_q, first_q, mul_go_q, div_go_q;
	logic [TIME_WIDTH-1:0] last_time_q;
	logic [DT_W-1:0] dt_q;
	logic signed [SW-1:0] s_q [3];
	logic signed [SW-1:0] rate_q [3];
	logic signed [SW-1:0] acc_q [3];
	logic signed [31:0] angle_q [3];
	logic signed [SW-1:0] ca_q;

	// output register
	logic res_valid_q, src_q;
	logic [31:0] out_q [9];

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_init, mul_prod;
	logic mul_busy, mul_done;
	logic [NW-1:0] div_quot;
	logic div_busy, div_done;

	logic [CFG_DATA_W-1:0] row_sel;
	logic signed [PACK_W-1:0] gb, ab, coef;
	logic signed [SW-1:0] cg, filt_new, ca_new;
	logic signed [AGW-1:0] inc, a_sum, a_wrap, a_sat;
	logic [TIME_WIDTH-1:0] t_diff;
	logic [DT_W-1:0] dt_new;
	logic fin_load;

	always_comb begin
		unique case (axis_q)
			2'd0: row_sel = row_x_q;
			2'd1: row_sel = row_y_q;
			default: row_sel = row_z_q;
		endcase
		unique case (axis_q)
			2'd0: begin gb = gbias_q[20:0]; ab = abias_q[20:0]; end
			2'd1: begin gb = gbias_q[41:21]; ab = abias_q[41:21]; end
			default: begin gb = gbias_q[62:42]; ab = abias_q[62:42]; end
		endcase
		unique case (term_q)
			2'd0: coef = row_sel[20:0];
			2'd1: coef = row_sel[41:21];
			default: coef = row_sel[62:42];
		endcase
	end

	assign cg = sat_sw(PW'(s_q[axis_q]) - PW'(gb));
	assign ca_new = sat_sw((mul_prod >>> 18) - PW'(ab));
	assign filt_new = sat_sw(PW'(state_q == ST_GFILT ? rate_q[axis_q] : acc_q[axis_q])
		+ (mul_prod >>> 16));

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_init = PW'(FILT_RND);
		case (state_q)
			ST_GFILT: begin
				mul_a = AW'(cg) - AW'(rate_q[axis_q]);
				mul_b = $signed(BW'(weight_q));
			end
			ST_AFILT: begin
				mul_a = AW'(ca_q) - AW'(acc_q[axis_q]);
				mul_b = $signed(BW'(weight_q));
			end
			ST_AMAT: begin
				mul_a = AW'(s_q[term_q]);
				mul_b = BW'(coef);
				mul_init = (term_q == 2'd0) ? PW'(MAT_RND) : mul_prod;
			end
			ST_INTMUL: begin
				mul_a = rate_q[axis_q][SW-1] ? -AW'(rate_q[axis_q]) : AW'(rate_q[axis_q]);
				mul_b = $signed(BW'({dt_q, 12'd0}));
				mul_init = PW'(INT_RND);
			end
			default: ;
		endcase
	end

	isc_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q),
		.a(mul_a), .b(mul_b), .init(mul_init),
		.busy(mul_busy), .done(mul_done), .prod(mul_prod)
	);

	isc_div #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.dividend(mul_prod[NW-1:0]),
		.busy(div_busy), .done(div_done), .quot(div_quot)
	);

	// angle update: signed step, wrap once, clamp
	always_comb begin
		inc = $signed(AGW'(div_quot));
		if (rate_q[axis_q][SW-1]) inc = -inc;
		a_sum = AGW'(angle_q[axis_q]) + inc;
		a_wrap = a_sum;
		if (a_sum > A_PI) a_wrap = a_sum - A_2PI;
		else if (a_sum < -A_PI) a_wrap = a_sum + A_2PI;
		a_sat = a_wrap;
		if (a_wrap > A_HI) a_sat = A_HI;
		else if (a_wrap < A_LO) a_sat = A_LO;
	end

	always_comb begin
		t_diff = time_us - last_time_q;
		dt_new = DT_DEFAULT;
		if (time_us > last_time_q && t_diff <= TIME_WIDTH'(DT_MAX)) dt_new = t_diff[DT_W-1:0];
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign fin_load = (state_q == ST_FIN) && (!res_valid_q || result_ready);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbias_q <= '0;
			abias_q <= '0;
			row_x_q <= ROW_X_RST;
			row_y_q <= ROW_Y_RST;
			row_z_q <= ROW_Z_RST;
			weight_q <= WEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GYRO_BIAS: gbias_q <= cfg_data;
				REG_ACCEL_BIAS: abias_q <= cfg_data;
				REG_ROW_X: row_x_q <= cfg_data;
				REG_ROW_Y: row_y_q <= cfg_data;
				REG_ROW_Z: row_z_q <= cfg_data;
				REG_WEIGHT: weight_q <= (cfg_data[WEIGHT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE
					: cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			term_q <= '0;
			op_q <= 1'b0;
			first_q <= 1'b1;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			last_time_q <= '0;
			dt_q <= DT_DEFAULT;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				rate_q[i] <= '0;
				acc_q[i] <= '0;
				angle_q[i] <= '0;
			end
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (fin_load) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						op_q <= operation;
						axis_q <= '0;
						term_q <= '0;
						if (operation) begin
							state_q <= ST_AMAT;
							mul_go_q <= 1'b1;
						end else begin
							last_time_q <= time_us;
							if (first_q) begin
								first_q <= 1'b0;
							end else begin
								dt_q <= dt_new;
								state_q <= ST_GFILT;
								mul_go_q <= 1'b1;
							end
						end
					end
				end
				ST_GFILT: begin
					if (mul_done) begin
						rate_q[axis_q] <= filt_new;
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
						if (axis_q == 2'd2) state_q <= ST_INTMUL;
						mul_go_q <= 1'b1;
					end
				end
				ST_INTMUL: begin
					if (mul_done) begin
						state_q <= ST_INTDIV;
						div_go_q <= 1'b1;
					end
				end
				ST_INTDIV: begin
					if (div_done) begin
						angle_q[axis_q] <= a_sat[31:0];
						if (axis_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= ST_INTMUL;
							mul_go_q <= 1'b1;
						end
					end
				end
				ST_AMAT: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						if (term_q == 2'd2) begin
							term_q <= '0;
							state_q <= ST_AFILT;
						end else begin
							term_q <= term_q + 2'd1;
						end
					end
				end
				ST_AFILT: begin
					if (mul_done) begin
						acc_q[axis_q] <= filt_new;
						if (axis_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= ST_AMAT;
							mul_go_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (fin_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			s_q[0] <= sample_x;
			s_q[1] <= sample_y;
			s_q[2] <= sample_z;
		end
		if (state_q == ST_AMAT && mul_done && term_q == 2'd2) ca_q <= ca_new;
		if (fin_load) begin
			src_q <= op_q;
			for (int i = 0; i < 3; i++) begin
				out_q[i] <= to32(rate_q[i]);
				out_q[3 + i] <= to32(acc_q[i]);
				out_q[6 + i] <= angle_q[i];
			end
		end
	end

	assign result_valid = res_valid_q;
	assign source = src_q;
	assign rate_x = out_q[0];
	assign rate_y = out_q[1];
	assign rate_z = out_q[2];
	assign accel_x = out_q[3];
	assign accel_y = out_q[4];
	assign accel_z = out_q[5];
	assign roll = out_q[6];
	assign pitch = out_q[7];
	assign yaw = out_q[8];

	`ISC_CHK(a_idle_quiet, sample_ready |-> !mul_busy && !div_busy, "units busy while idle")
	`ISC_CHK(a_div_state, div_done |-> state_q == ST_INTDIV, "divide finished outside step")
	`ISC_CHK(a_mul_state, mul_done |-> state_q == ST_GFILT || state_q == ST_INTMUL || state_q == ST_AMAT || state_q == ST_AFILT, "multiply finished in wrong state")
	`ISC_NEXT(a_fin_load, fin_load, result_valid && state_q == ST_IDLE, "result not loaded")

endmodule

// File: tb/isc_tb_pkg.sv
// Sample source codes shared by the conditioner testbench files
`timescale 1ns / 100ps
package isc_tb_pkg;

	localparam logic OP_GYRO = 1'b0;
	localparam logic OP_ACCEL = 1'b1;

endpackage

// File: tb/isc_checker.sv
// Channel monitor, conditioner predictor and result scoreboard
`timescale 1ns / 100ps
module isc_checker import isc_pkg::*, isc_tb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  logic                  operation,
	input  logic signed [31:0]    sample_x,
	input  logic signed [31:0]    sample_y,
	input  logic signed [31:0]    sample_z,
	input  logic [47:0]           time_us,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic                  source,
	input  logic signed [31:0]    rate_x,
	input  logic signed [31:0]    rate_y,
	input  logic signed [31:0]    rate_z,
	input  logic signed [31:0]    accel_x,
	input  logic signed [31:0]    accel_y,
	input  logic signed [31:0]    accel_z,
	input  logic signed [31:0]    roll,
	input  logic signed [31:0]    pitch,
	input  logic signed [31:0]    yaw,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending
);

	typedef struct {
		logic              src;
		logic signed [31:0] val [9];
	} cond_word_t;

	string field_name [9] = '{"rate_x", "rate_y", "rate_z", "accel_x", "accel_y", "accel_z",
		"roll", "pitch", "yaw"};

	cond_word_t expected_words [$];

	logic [CFG_DATA_W-1:0] gyro_bias, accel_bias;
	logic [CFG_DATA_W-1:0] mat_row [3];
	logic [WEIGHT_W-1:0] weight;
	logic first_pend;
	logic [47:0] last_time;
	longint rate_st [3], accel_st [3], angle_st [3];

	assign pending = expected_words.size();

	function automatic longint sext(longint v, int w);
		return (v <<< (64 - w)) >>> (64 - w);
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint coef(logic [CFG_DATA_W-1:0] r, int k);
		return sext(longint'(r >> (PACK_W * k)), PACK_W);
	endfunction

	function automatic longint smooth(longint x, longint p, longint w);
		longint d, dh, dl;
		d = x - p;
		dh = d >>> 16;
		dl = d - dh * 65536;
		return clip(p + w * dh + ((w * dl + FILT_RND) >>> 16), 32);
	endfunction

	function automatic longint row_dot(logic [CFG_DATA_W-1:0] r, longint s [3]);
		longint hi, lo, c, sh;
		hi = 0;
		lo = 0;
		for (int j = 0; j < 3; j++) begin
			c = coef(r, j);
			sh = s[j] >>> 18;
			hi += c * sh;
			lo += c * (s[j] - sh * 262144);
		end
		return hi + ((lo + MAT_RND) >>> 18);
	endfunction

	function automatic longint advance_angle(longint a, longint r, longint unsigned dt);
		longint unsigned mag, m, q, rm;
		longint inc;
		mag = r < 0 ? longint'(-r) : longint'(r);
		m = mag * dt;
		q = m / 1000000;
		rm = m % 1000000;
		inc = longint'(q * 4096 + (rm * 4096 + INT_RND) / 1000000);
		if (r < 0)
			inc = -inc;
		a += inc;
		if (a > PI_Q)
			a -= TWO_PI_Q;
		else if (a < -PI_Q)
			a += TWO_PI_Q;
		return clip(a, 32);
	endfunction

	task automatic predict_word();
		longint s [3];
		longint w;
		longint unsigned dt;
		cond_word_t cw;
		s[0] = longint'(sample_x);
		s[1] = longint'(sample_y);
		s[2] = longint'(sample_z);
		w = (weight > WEIGHT_ONE) ? 65536 : longint'(weight);
		if (operation == OP_GYRO) begin
			if (first_pend) begin
				// first gyro word only seeds the timestamp
				first_pend = 1'b0;
				last_time = time_us;
				return;
			end
			for (int i = 0; i < 3; i++)
				rate_st[i] = smooth(clip(s[i] - coef(gyro_bias, i), 32), rate_st[i], w);
			dt = (time_us > last_time) ? longint'(time_us - last_time) : 0;
			if (dt == 0 || dt > 100000)
				dt = 10000;
			last_time = time_us;
			for (int i = 0; i < 3; i++)
				angle_st[i] = advance_angle(angle_st[i], rate_st[i], dt);
		end else begin
			for (int i = 0; i < 3; i++)
				accel_st[i] = smooth(clip(row_dot(mat_row[i], s) - coef(accel_bias, i), 32),
					accel_st[i], w);
		end
		cw.src = operation;
		for (int i = 0; i < 3; i++) begin
			cw.val[i] = rate_st[i][31:0];
			cw.val[3 + i] = accel_st[i][31:0];
			cw.val[6 + i] = angle_st[i][31:0];
		end
		expected_words.push_back(cw);
	endtask

	task automatic check_word();
		cond_word_t cw;
		logic signed [31:0] got [9];
		got = '{rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, roll, pitch, yaw};
		if (expected_words.size() == 0) begin
			$error("unexpected result word, source %0d", source);
			fails++;
			return;
		end
		cw = expected_words.pop_front();
		if (source !== cw.src) begin
			$error("source: expected %0d, actual %0d", cw.src, source);
			fails++;
		end
		for (int i = 0; i < 9; i++)
			if (got[i] !== cw.val[i]) begin
				$error("%s: expected %0d, actual %0d", field_name[i], cw.val[i], got[i]);
				fails++;
			end
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_bias = '0;
			accel_bias = '0;
			mat_row[0] = ROW_X_RST;
			mat_row[1] = ROW_Y_RST;
			mat_row[2] = ROW_Z_RST;
			weight = WEIGHT_RST;
			first_pend = 1'b1;
			last_time = '0;
			for (int i = 0; i < 3; i++) begin
				rate_st[i] = 0;
				accel_st[i] = 0;
				angle_st[i] = 0;
			end
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GYRO_BIAS: gyro_bias = cfg_data;
					REG_ACCEL_BIAS: accel_bias = cfg_data;
					REG_ROW_X: mat_row[0] = cfg_data;
					REG_ROW_Y: mat_row[1] = cfg_data;
					REG_ROW_Z: mat_row[2] = cfg_data;
					REG_WEIGHT: weight = cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready)
				check_word();
			if (sample_valid && sample_ready)
				predict_word();
		end
	end

endmodule

// File: tb/tb_top.sv
// Stimulus, handshake pacing and verdict for the IMU sample conditioner
`timescale 1ns / 100ps
module tb_top import isc_pkg::*, isc_tb_pkg::*;;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic operation = OP_GYRO;
	logic signed [31:0] sample_x = '0, sample_y = '0, sample_z = '0;
	logic [47:0] time_us = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic source;
	logic signed [31:0] rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, roll, pitch, yaw;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fails, pending;

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	logic [47:0] clock_us = '0;
	int cycles = 0;

	imu_sample_conditioner uut (.*);

	isc_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** imu_sample_conditioner: FAILED **");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready = 1'b0;
				repeat (3000) @(negedge clk);
			end else if (stall > 0) begin
				result_ready = 1'b0;
				stall--;
			end else begin
				result_ready = 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 3);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 9);
		return r < 5 ? 0 : (r < 9 ? $urandom_range(1, 3) : $urandom_range(20, 80));
	endfunction

	function automatic logic [31:0] pick_reading();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg();
		logic [20:0] c [3];
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return CFG_DATA_W'({$urandom, $urandom});
			default: begin
				for (int i = 0; i < 3; i++)
					c[i] = 21'($urandom_range(0, 1 << 19)) - 21'(1 << 18);
				return {c[2], c[1], c[0]};
			end
		endcase
	endfunction

	// timestamps: mostly sane steps, with stalls, reversals, long gaps and jumps
	function automatic logic [47:0] next_time();
		case ($urandom_range(0, 19))
			0: clock_us = clock_us;
			1: clock_us = clock_us - 48'($urandom_range(1, 5000));
			2: clock_us = clock_us + 48'($urandom_range(100001, 2000000));
			3: clock_us = 48'({$urandom, $urandom});
			default: clock_us = clock_us + 48'($urandom_range(1, 100000));
		endcase
		return clock_us;
	endfunction

	// entered and left at a falling edge
	task automatic send_word(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [47:0] t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		sample_x = x;
		sample_y = y;
		sample_z = z;
		time_us = t;
		sample_valid = 1'b1;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	task automatic send_random();
		if ($urandom_range(0, 1))
			send_word(OP_GYRO, pick_reading(), pick_reading(), pick_reading(), next_time());
		else
			send_word(OP_ACCEL, pick_reading(), pick_reading(), pick_reading(),
				48'({$urandom, $urandom}));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		sample_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first gyro seeds time, then the time step corner cases, then three accel words
		send_word(OP_GYRO, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 48'd1000);
		send_word(OP_GYRO, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 48'd1000);
		send_word(OP_GYRO, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 48'd500);
		send_word(OP_GYRO, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 48'd100500);
		send_word(OP_GYRO, 32'h0003_0000, 32'd0, 32'hFFFF_FFFF, 48'd200501);
		send_word(OP_GYRO, 32'hFFFF_FFFF, 32'h0000_0001, 32'd12345, 48'hFFFF_FFFF_FFF0);
		send_word(OP_GYRO, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd5);
		send_word(OP_GYRO, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd100005);
		send_word(OP_ACCEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 48'hFFFF_FFFF_FFFF);
		send_word(OP_ACCEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'd0);
		send_word(OP_ACCEL, 32'h0009_CCCD, 32'd0, 32'hFFF6_3333, 48'd0);
		drain();

		write_reg(REG_WEIGHT, CFG_DATA_W'(WEIGHT_ONE));
		write_reg(REG_GYRO_BIAS, '1);
		write_reg(REG_ACCEL_BIAS, '1);
		write_reg(REG_ROW_X, '1);
		write_reg(REG_ROW_Y, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
		write_reg(REG_ROW_Z, {21'h100000, 21'h0FFFFF, 21'h100000});
		write_reg(3'd6, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(3'd7, '1);
		send_word(OP_ACCEL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd0);
		send_word(OP_ACCEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'd0);
		send_word(OP_GYRO, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 48'd200000);
		drain();
		// weight beyond one acts as one; zero freezes the filter
		write_reg(REG_WEIGHT, CFG_DATA_W'(17'h1FFFF));
		send_word(OP_GYRO, 32'h0010_0000, 32'h8000_0000, 32'h7FFF_FFFF, 48'd210000);
		send_word(OP_ACCEL, 32'h0010_0000, 32'hFFF0_0000, 32'd0, 48'd0);
		drain();
		write_reg(REG_WEIGHT, CFG_DATA_W'(17'd0));
		send_word(OP_GYRO, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 48'd220000);
		send_word(OP_ACCEL, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 48'd0);
		drain();

		clock_us = 48'd300000;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_GYRO_BIAS, pick_reg());
			write_reg(REG_ACCEL_BIAS, pick_reg());
			write_reg(REG_ROW_X, ph == 0 ? ROW_X_RST : pick_reg());
			write_reg(REG_ROW_Y, ph == 0 ? ROW_Y_RST : pick_reg());
			write_reg(REG_ROW_Z, ph == 0 ? ROW_Z_RST : pick_reg());
			write_reg(REG_WEIGHT,
				CFG_DATA_W'(ph == 1 ? WEIGHT_ONE : 17'($urandom_range(0, 70000))));
			calm = (ph == 2);
			for (int n = 0; n < 100; n++) begin
				if (ph == 3 && n == 40) begin
					// long result hold-off while words keep coming
					hold_req = 1'b1;
					calm = 1'b1;
					repeat (12) send_random();
					calm = 1'b0;
				end
				if (n == 70)
					drain();
				send_random();
			end
			drain();
		end
		calm = 1'b0;

		if (fails == 0)
			$display("** imu_sample_conditioner: PASSED **");
		else
			$display("** imu_sample_conditioner: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/isc_pkg.sv
sv/isc_mul.sv
sv/isc_div.sv
sv/imu_sample_conditioner.sv
tb/isc_tb_pkg.sv
tb/isc_checker.sv
tb/tb_top.sv
